// ===== rtl/core/ric_pkg.sv =====
// Random-index context accumulator: shared types, constants and a helper function.
// No dependencies; ric_fifo, ric_front, ric_back and the top level import this package.
`default_nettype none

package ric_pkg;

    // Context store geometry
    localparam int VECTOR_BITS = 8192;
    localparam int POS_W       = $clog2(VECTOR_BITS);
    localparam int NBANK       = 8;
    localparam int BANK_W      = $clog2(NBANK);
    localparam int ROW_W       = POS_W - BANK_W;
    localparam int ROWS        = VECTOR_BITS / NBANK;
    localparam int CTR_W       = 32;

    // Item fields
    localparam int WEIGHT_W    = 5;
    localparam int WORD_W      = 7;
    localparam int HASH_W      = 64;
    localparam int SIGN_W      = 64;
    localparam int BEAT_W      = ROW_W - WORD_W;   // rows per sign word, log2

    // Op queue between front and back
    localparam int Q_DEPTH     = 4;
    localparam int Q_AW        = $clog2(Q_DEPTH);

    // splitmix64
    localparam logic [63:0] GOLDEN  = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [63:0] MIX_ONE = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [63:0] MIX_TWO = 64'h94D0_49BB_1331_11EB;

    typedef enum logic [1:0] {
        ACT_ADD   = 2'd0,
        ACT_READ  = 2'd1,
        ACT_CLEAR = 2'd2
    } t_action;

    typedef enum logic [2:0] {
        OPK_PLUS  = 3'd0,
        OPK_MINUS = 3'd1,
        OPK_READ  = 3'd2,
        OPK_CLEAR = 3'd3,
        OPK_NONE  = 3'd4
    } t_op_kind;

    typedef struct packed {
        t_op_kind              kind;
        logic [WEIGHT_W-1:0]   weight;
        logic [WORD_W-1:0]     word;
        logic                  last;
        logic [POS_W-1:0]      pos;
    } t_op;

    typedef struct packed {
        logic init_done;
    } t_bk_status;

    typedef enum logic [2:0] {
        BK_INIT = 3'd0,
        BK_IDLE = 3'd1,
        BK_UPD  = 3'd2,
        BK_GATH = 3'd3,
        BK_CLR  = 3'd4,
        BK_DONE = 3'd5
    } t_bk_state;

    typedef struct packed {
        logic [CTR_W-1:0] value;
        logic             clamp;
    } t_upd;

    // Saturating counter update by +w or -w
    function automatic t_upd sat_add(input logic [CTR_W-1:0] c, input logic minus,
                                     input logic [WEIGHT_W-1:0] w);
        logic signed [CTR_W:0] d;
        logic signed [CTR_W:0] v;
        t_upd                  r;
        d = $signed({{(CTR_W + 1 - WEIGHT_W){1'b0}}, w});
        if (minus) begin
            d = -d;
        end
        v = $signed({c[CTR_W-1], c}) + d;
        r.clamp = v[CTR_W] ^ v[CTR_W-1];
        if (r.clamp) begin
            r.value = v[CTR_W] ? {1'b1, {(CTR_W-1){1'b0}}} : {1'b0, {(CTR_W-1){1'b1}}};
        end else begin
            r.value = v[CTR_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ric_intf.sv =====
// Channel interfaces of the random-index context accumulator: item in, result out.
// Valid/ready handshake; a beat moves when both are high. No dependencies.
`default_nettype none

interface ric_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [63:0] source_hash;
    logic [4:0]  weight;
    logic [6:0]  word_index;

    modport source (output valid, output action, output source_hash, output weight,
                    output word_index, input ready);
    modport sink   (input valid, input action, input source_hash, input weight,
                    input word_index, output ready);
endinterface

interface ric_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] sign_word;
    logic        saturated;

    modport source (output valid, output sign_word, output saturated, input ready);
    modport sink   (input valid, input sign_word, input saturated, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ric_fifo.sv =====
// Short op queue between the front (position generator) and the back (counter store).
// Depends on ric_pkg.
`default_nettype none

module ric_fifo (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire ric_pkg::t_op i_op,
    output logic              o_full,
    input  wire logic         i_pop,
    output ric_pkg::t_op      o_op,
    output logic              o_empty
);
    import ric_pkg::*;

    t_op             r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr;
    logic [Q_AW-1:0] r_rd;
    logic [Q_AW:0]   r_cnt;

    assign o_full  = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_op    = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + Q_AW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + Q_AW'(1);
            end
            r_cnt <= r_cnt + (Q_AW+1)'(i_push) - (Q_AW+1)'(i_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("op queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("op queue read while empty");

endmodule

`default_nettype wire

// ===== rtl/core/ric_front.sv =====
// Front of the accumulator: takes items, classifies them and runs the splitmix64
// position generator as a five-stage pipeline into the op queue. Depends on ric_pkg, ric_intf.
`default_nettype none

module ric_front #(
    parameter int INDEX_PAIRS = 12
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    ric_in_if.sink                   i_in,
    input  wire ric_pkg::t_bk_status i_bk,
    input  wire logic                i_q_full,
    output logic                     o_push,
    output ric_pkg::t_op             o_op
);
    import ric_pkg::*;

    localparam int CNT_W = $clog2(2 * INDEX_PAIRS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(2 * INDEX_PAIRS - 1);

    // draw sequencer
    logic                r_busy;
    logic [CNT_W-1:0]    r_cnt;
    logic [63:0]         r_seed;
    logic [WEIGHT_W-1:0] r_weight;
    logic                n_busy;
    logic [CNT_W-1:0]    n_cnt;
    logic [63:0]         n_seed;
    logic [WEIGHT_W-1:0] n_weight;

    // pipeline
    logic        r_v [5];
    t_op         r_op [5];
    logic [63:0] r_z0;
    logic [63:0] r_a_ll;
    logic [31:0] r_a_hl;
    logic [31:0] r_a_lh;
    logic [63:0] r_z1;
    logic [63:0] r_b_ll;
    logic [31:0] r_b_hl;
    logic [31:0] r_b_lh;
    logic [63:0] r_z2;

    logic        w_en;
    logic        w_ready;
    logic        w_accept;
    logic        w_iss_v;
    t_op         w_iss_op;
    logic [63:0] w_iss_z;
    logic [63:0] w_x;
    logic [63:0] w_y;
    logic [63:0] w_fin;

    assign w_en     = !r_v[4] || !i_q_full;
    assign w_ready  = !r_busy && w_en && i_bk.init_done;
    assign w_accept = i_in.valid && w_ready;
    assign i_in.ready = w_ready;

    always_comb begin
        n_busy   = r_busy;
        n_cnt    = r_cnt;
        n_seed   = r_seed;
        n_weight = r_weight;
        w_iss_v  = 1'b0;
        w_iss_op = '0;
        w_iss_z  = r_seed + GOLDEN;
        if (r_busy) begin
            if (w_en) begin
                w_iss_v         = 1'b1;
                w_iss_op.kind   = r_cnt[0] ? OPK_MINUS : OPK_PLUS;
                w_iss_op.weight = r_weight;
                w_iss_op.last   = (r_cnt == CNT_LAST);
                n_seed          = w_iss_z;
                n_cnt           = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_LAST) begin
                    n_busy = 1'b0;
                end
            end
        end else if (w_accept) begin
            w_iss_v = 1'b1;
            unique case (t_action'(i_in.action))
                ACT_ADD: begin
                    w_iss_z         = i_in.source_hash + GOLDEN;
                    w_iss_op.kind   = OPK_PLUS;
                    w_iss_op.weight = i_in.weight;
                    n_seed          = w_iss_z;
                    n_weight        = i_in.weight;
                    n_cnt           = CNT_W'(1);
                    n_busy          = 1'b1;
                end
                ACT_READ: begin
                    w_iss_op.kind = OPK_READ;
                    w_iss_op.word = i_in.word_index;
                    w_iss_op.last = 1'b1;
                end
                ACT_CLEAR: begin
                    w_iss_op.kind = OPK_CLEAR;
                    w_iss_op.last = 1'b1;
                end
                default: begin
                    w_iss_op.kind = OPK_NONE;
                    w_iss_op.last = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_v    <= '{default: 1'b0};
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
            if (w_en) begin
                r_v[0] <= w_iss_v;
                for (int k = 1; k < 5; k++) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // mix steps; each multiply is three 32x32 partial products, summed a stage later
    assign w_x   = r_z0 ^ (r_z0 >> 30);
    assign w_y   = r_z1 ^ (r_z1 >> 27);
    assign w_fin = r_z2 ^ (r_z2 >> 31);

    always_ff @(posedge i_clk) begin
        r_seed   <= n_seed;
        r_weight <= n_weight;
        if (w_en) begin
            r_op[0] <= w_iss_op;
            for (int k = 1; k < 5; k++) begin
                r_op[k] <= r_op[k-1];
            end
            r_z0   <= w_iss_z;
            r_a_ll <= w_x[31:0] * MIX_ONE[31:0];
            r_a_hl <= w_x[63:32] * MIX_ONE[31:0];
            r_a_lh <= w_x[31:0] * MIX_ONE[63:32];
            r_z1   <= r_a_ll + {r_a_hl + r_a_lh, 32'b0};
            r_b_ll <= w_y[31:0] * MIX_TWO[31:0];
            r_b_hl <= w_y[63:32] * MIX_TWO[31:0];
            r_b_lh <= w_y[31:0] * MIX_TWO[63:32];
            r_z2   <= r_b_ll + {r_b_hl + r_b_lh, 32'b0};
        end
    end

    assign o_push = r_v[4] && !i_q_full;

    always_comb begin
        o_op     = r_op[4];
        o_op.pos = w_fin[POS_W-1:0];
    end

    a_hold_during_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_bk.init_done |-> !i_in.ready)
        else $error("item taken while the store is still being cleared");

endmodule

`default_nettype wire

// ===== rtl/core/ric_back.sv =====
// Back of the accumulator: banked counter store, saturating read-modify-write,
// sign-word gather, clearing sweeps and the result register. Depends on ric_pkg, ric_intf.
`default_nettype none

module ric_back (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_q_empty,
    input  wire ric_pkg::t_op i_q_op,
    output logic              o_pop,
    output ric_pkg::t_bk_status o_bk,
    ric_out_if.source         o_out
);
    import ric_pkg::*;

    localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(ROWS - 1);
    localparam logic [BEAT_W-1:0] BEAT_LAST = '1;

    t_bk_state           r_state;
    t_bk_state           n_state;
    logic [ROW_W-1:0]    r_row;
    logic [ROW_W-1:0]    n_row;
    logic [BEAT_W-1:0]   r_beat;
    logic [BEAT_W-1:0]   n_beat;
    logic [WORD_W-1:0]   r_word;
    logic [WORD_W-1:0]   n_word;
    t_op                 r_cur;
    t_op                 n_cur;
    logic                r_sat;
    logic                n_sat;
    logic [SIGN_W-1:0]   r_sign;
    logic [SIGN_W-1:0]   n_sign;
    logic                r_o_valid;
    logic                n_o_valid;
    logic [SIGN_W-1:0]   r_o_sign;
    logic [SIGN_W-1:0]   n_o_sign;
    logic                r_o_sat;
    logic                n_o_sat;

    logic [CTR_W-1:0]    r_rdata [NBANK];
    logic [NBANK-1:0]    w_we;
    logic [ROW_W-1:0]    w_waddr;
    logic [ROW_W-1:0]    w_raddr;
    logic [CTR_W-1:0]    w_wdata;
    t_upd                w_upd;

    // counter banks: bank = pos low bits, row = pos high bits
    for (genvar b = 0; b < NBANK; b++) begin : g_bank
        logic [CTR_W-1:0] mem [ROWS];
        always_ff @(posedge i_clk) begin
            if (w_we[b]) begin
                mem[w_waddr] <= w_wdata;
            end
            r_rdata[b] <= mem[w_raddr];
        end
    end

    assign w_upd = sat_add(r_rdata[r_cur.pos[BANK_W-1:0]], r_cur.kind == OPK_MINUS,
                           r_cur.weight);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_row     = r_row;
        n_beat    = r_beat;
        n_word    = r_word;
        n_cur     = r_cur;
        n_sat     = r_sat;
        n_sign    = r_sign;
        n_o_valid = r_o_valid && !o_out.ready;
        n_o_sign  = r_o_sign;
        n_o_sat   = r_o_sat;
        o_pop     = 1'b0;
        w_we      = '0;
        w_waddr   = r_row;
        w_wdata   = '0;
        w_raddr   = {r_word, r_beat + BEAT_W'(1)};
        unique case (r_state)
            BK_INIT: begin
                w_we  = '1;
                n_row = r_row + ROW_W'(1);
                if (r_row == ROW_LAST) begin
                    n_state = BK_IDLE;
                end
            end
            BK_IDLE: begin
                if (!i_q_empty) begin
                    o_pop = 1'b1;
                    n_cur = i_q_op;
                    unique case (i_q_op.kind)
                        OPK_PLUS, OPK_MINUS: begin
                            w_raddr = i_q_op.pos[POS_W-1:BANK_W];
                            n_state = BK_UPD;
                        end
                        OPK_READ: begin
                            w_raddr = {i_q_op.word, BEAT_W'(0)};
                            n_word  = i_q_op.word;
                            n_beat  = '0;
                            n_state = BK_GATH;
                        end
                        OPK_CLEAR: begin
                            n_row   = '0;
                            n_state = BK_CLR;
                        end
                        default: begin
                            n_state = BK_DONE;
                        end
                    endcase
                end
            end
            BK_UPD: begin
                w_we    = NBANK'(1) << r_cur.pos[BANK_W-1:0];
                w_waddr = r_cur.pos[POS_W-1:BANK_W];
                w_wdata = w_upd.value;
                n_sat   = r_sat | w_upd.clamp;
                n_state = r_cur.last ? BK_DONE : BK_IDLE;
            end
            BK_GATH: begin
                for (int j = 0; j < NBANK; j++) begin
                    n_sign[{r_beat, BANK_W'(j)}] = !r_rdata[j][CTR_W-1] && (r_rdata[j] != '0);
                end
                n_beat = r_beat + BEAT_W'(1);
                if (r_beat == BEAT_LAST) begin
                    n_state = BK_DONE;
                end
            end
            BK_CLR: begin
                w_we  = '1;
                n_row = r_row + ROW_W'(1);
                if (r_row == ROW_LAST) begin
                    n_state = BK_DONE;
                end
            end
            BK_DONE: begin
                if (!r_o_valid || o_out.ready) begin
                    n_o_valid = 1'b1;
                    n_o_sign  = r_sign;
                    n_o_sat   = r_sat;
                    n_sign    = '0;
                    n_sat     = 1'b0;
                    n_state   = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row     <= '0;
            r_beat    <= '0;
            r_sat     <= 1'b0;
            r_sign    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_row     <= n_row;
            r_beat    <= n_beat;
            r_sat     <= n_sat;
            r_sign    <= n_sign;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word   <= n_word;
        r_cur    <= n_cur;
        r_o_sign <= n_o_sign;
        r_o_sat  <= n_o_sat;
    end

    assign o_bk.init_done  = (r_state != BK_INIT);
    assign o_out.valid     = r_o_valid;
    assign o_out.sign_word = r_o_sign;
    assign o_out.saturated = r_o_sat;

    a_upd_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_UPD) |-> ($past(r_state) == BK_IDLE))
        else $error("counter write without a preceding read");

    a_no_pop_in_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_INIT) |-> !o_pop)
        else $error("op taken during the reset sweep");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_valid) |-> ($past(r_state) == BK_DONE))
        else $error("result raised outside the completion state");

endmodule

`default_nettype wire

// ===== rtl/core/random_index_context_accumulator_top.sv =====
// Top level of the random-index context accumulator.
// Depends on ric_pkg, ric_intf, ric_fifo, ric_front and ric_back.
//
// Use:
//   i_in carries one item per beat: action 0 adds an index vector drawn from
//   source_hash with the given weight, 1 reads the sign word at word_index,
//   2 clears all 8192 counters; any other action does nothing. Every item
//   gives exactly one beat on o_out (sign_word, saturated), in item order.
//
// Timing:
//   The front turns an add into 2*INDEX_PAIRS position draws, one a cycle
//   while the op queue has room, through a five-stage splitmix64 pipeline
//   (each 64-bit multiply is three 32x32 partial products and a sum). The
//   back does one read-modify-write per draw on the eight-bank counter store,
//   reading the counter as it takes the op and writing it in the update
//   state, then loads the result register; the back store port sets the
//   sustained rate. A read gathers 8 counters a cycle for a 64-bit word; a
//   clear sweeps 1024 rows, one a cycle.
//
// Reset and stalls:
//   After reset a sweep of all 1024 rows zeroes the store; i_in.ready
//   stays low until it ends. A stalled o_out holds its beat in the result
//   register; the back and then the four-entry op queue fill, and the front
//   stops taking items when its pipeline cannot drain.
`default_nettype none

module random_index_context_accumulator_top #(
    parameter int INDEX_PAIRS = 12
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ric_in_if.sink    i_in,
    ric_out_if.source o_out
);
    import ric_pkg::*;

    logic       w_push;
    t_op        w_push_op;
    logic       w_full;
    logic       w_pop;
    t_op        w_head_op;
    logic       w_empty;
    t_bk_status w_bk;

    ric_front #(
        .INDEX_PAIRS(INDEX_PAIRS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_bk     (w_bk),
        .i_q_full (w_full),
        .o_push   (w_push),
        .o_op     (w_push_op)
    );

    ric_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_op    (w_push_op),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_op    (w_head_op),
        .o_empty (w_empty)
    );

    ric_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (w_empty),
        .i_q_op    (w_head_op),
        .o_pop     (w_pop),
        .o_bk      (w_bk),
        .o_out     (o_out)
    );

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking bench for random_index_context_accumulator_top: drives item beats, predicts
// every result from its own counter store and compares. Needs ric_pkg, ric_in_if and
// ric_out_if from rtl/core, and the top level with everything below it.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ric_pkg::*;

    localparam int          INDEX_PAIRS = 12;
    localparam int          NUM_RANDOM  = 2000;
    localparam int          HANG_LIMIT  = 20000;  // idle cycles without a beat on either channel
    localparam int          TAIL_CYCLES = 120;
    localparam int          REPORT_MAX  = 10;
    localparam logic [1:0]  ACT_UNDEF   = 2'd3;   // not decoded by the block: result all zero

    typedef struct {
        logic [1:0]          action;
        logic [HASH_W-1:0]   hash;
        logic [WEIGHT_W-1:0] weight;
        logic [WORD_W-1:0]   word;
        int                  gap;    // idle cycles before this beat is offered
        bit                  drain;  // hold the beat back until nothing is outstanding
    } ric_item_t;

    typedef struct packed {
        logic [SIGN_W-1:0] sign_word;
        logic              saturated;
    } ric_result_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ric_in_if  in_if ();
    ric_out_if out_if ();

    random_index_context_accumulator_top #(
        .INDEX_PAIRS(INDEX_PAIRS)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    always #6 i_clk = ~i_clk;

    // Shadow copy of the context vector
    int          ctx_ctr [VECTOR_BITS];

    ric_item_t   item_q [$];         // beats still to be offered
    ric_result_t result_q [$];       // predicted results, oldest first
    int          fault_count = 0;
    int          idle_cycles = 0;
    int          cycle_count = 0;
    logic        in_took     = 1'b0; // beat moved on i_in at the last rising edge
    ric_item_t   staged;
    bit          have_staged = 1'b0;
    int          gap_left    = 0;
    int          stall_left  = 0;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // n-th splitmix64 draw from a seed: the seed moves on by the golden step before
    // each draw, so draw n sees seed + (n+1) steps. Only the low bits pick a counter.
    function automatic logic [POS_W-1:0] draw_pos(logic [63:0] seed, int n);
        logic [63:0] z;
        z = seed + GOLDEN * 64'(n + 1);
        z = (z ^ (z >> 30)) * MIX_ONE;
        z = (z ^ (z >> 27)) * MIX_TWO;
        z = z ^ (z >> 31);
        return z[POS_W-1:0];
    endfunction

    // Saturating update of one shadow counter; 1 when it clamped.
    function automatic bit bump_ctr(int unsigned p, longint delta);
        longint v;
        bit     clamped;
        v       = longint'(ctx_ctr[p]) + delta;
        clamped = 1'b0;
        if (v > longint'(32'sh7FFF_FFFF)) begin
            v       = longint'(32'sh7FFF_FFFF);
            clamped = 1'b1;
        end else if (v < -longint'(64'sh8000_0000)) begin
            v       = -longint'(64'sh8000_0000);
            clamped = 1'b1;
        end
        ctx_ctr[p] = int'(v);
        return clamped;
    endfunction

    // Applies one accepted item to the shadow store and returns its result.
    function automatic ric_result_t apply_item(ric_item_t it);
        ric_result_t res;
        longint      w;
        int unsigned idx;
        res = '0;
        w   = longint'(it.weight);
        case (it.action)
            ACT_ADD: begin
                // plus draw then minus draw, pair by pair; repeats simply stack
                for (int k = 0; k < INDEX_PAIRS; k++) begin
                    if (bump_ctr(draw_pos(it.hash, 2 * k), w)) begin
                        res.saturated = 1'b1;
                    end
                    if (bump_ctr(draw_pos(it.hash, 2 * k + 1), -w)) begin
                        res.saturated = 1'b1;
                    end
                end
            end
            ACT_READ: begin
                for (int i = 0; i < SIGN_W; i++) begin
                    idx = it.word * SIGN_W + i;
                    if (idx < VECTOR_BITS && ctx_ctr[idx] > 0) begin
                        res.sign_word[i] = 1'b1;
                    end
                end
            end
            ACT_CLEAR: begin
                foreach (ctx_ctr[i]) begin
                    ctx_ctr[i] = 0;
                end
            end
            default: ;  // unknown action leaves the store alone
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Monitor: both channels sampled at the rising edge
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        ric_item_t   seen;
        ric_result_t got;
        ric_result_t want;
        in_took <= in_if.valid && in_if.ready;
        if (i_rst_n) begin
            cycle_count <= cycle_count + 1;
            // result side first: a result can never belong to a beat taken at this edge
            if (out_if.valid && out_if.ready) begin
                got.sign_word = out_if.sign_word;
                got.saturated = out_if.saturated;
                if (result_q.size() == 0) begin
                    if (fault_count < REPORT_MAX) begin
                        $display("%0t: result beat with nothing outstanding: sign %h sat %b",
                                 $realtime, got.sign_word, got.saturated);
                    end
                    fault_count <= fault_count + 1;
                end else begin
                    want = result_q.pop_front();
                    if (got.sign_word !== want.sign_word || got.saturated !== want.saturated)
                    begin
                        if (fault_count < REPORT_MAX) begin
                            $display("%0t: mismatch: sign exp %h got %h, sat exp %b got %b",
                                     $realtime, want.sign_word, got.sign_word,
                                     want.saturated, got.saturated);
                        end
                        fault_count <= fault_count + 1;
                    end
                end
            end
            if (in_if.valid && in_if.ready) begin
                seen.action = in_if.action;
                seen.hash   = in_if.source_hash;
                seen.weight = in_if.weight;
                seen.word   = in_if.word_index;
                seen.gap    = 0;
                seen.drain  = 1'b0;
                result_q.insert(result_q.size(), apply_item(seen));
            end
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Mostly short pauses, now and then a long one.
    function automatic int pause_len();
        if ($urandom_range(0, 99) < 80) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 48);
    endfunction

    // ------------------------------------------------------------------
    // Item driver: updates at the falling edge
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (in_if.valid && !in_took) begin
                // beat still on offer: hold everything
            end else begin
                if (!have_staged && item_q.size() > 0) begin
                    staged      = item_q.pop_front();
                    have_staged = 1'b1;
                    gap_left    = staged.gap;
                end
                if (have_staged && gap_left == 0 && !(staged.drain && result_q.size() != 0))
                begin
                    in_if.action      <= staged.action;
                    in_if.source_hash <= staged.hash;
                    in_if.weight      <= staged.weight;
                    in_if.word_index  <= staged.word;
                    in_if.valid       <= 1'b1;
                    have_staged = 1'b0;
                end else begin
                    in_if.valid <= 1'b0;
                    if (have_staged && gap_left > 0) begin
                        gap_left = gap_left - 1;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result sink: random back-pressure, with spells of none at all
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (stall_left > 0) begin
                out_if.ready <= 1'b0;
                stall_left = stall_left - 1;
            end else if ((cycle_count / 3000) % 4 == 1 || $urandom_range(0, 99) >= 25) begin
                out_if.ready <= 1'b1;
            end else begin
                out_if.ready <= 1'b0;
                stall_left = pause_len() - 1;
            end
        end
    end

    task automatic queue_item(logic [1:0] act, logic [63:0] h, logic [4:0] w, logic [6:0] wd,
                              int gap, bit drain);
        ric_item_t it;
        it.action = act;
        it.hash   = h;
        it.weight = w;
        it.word   = wd;
        it.gap    = gap;
        it.drain  = drain;
        item_q.insert(item_q.size(), it);
    endtask

    // ------------------------------------------------------------------
    // Stimulus, reset and end of run
    // ------------------------------------------------------------------
    initial begin
        logic [63:0]      hash_pool [16];
        logic [63:0]      h;
        logic [63:0]      twin_hash;
        logic [POS_W-1:0] p;
        logic [POS_W-1:0] q;
        logic [1:0]       act;
        logic [4:0]       w;
        logic [6:0]       wd;
        logic [6:0]       last_word;
        logic [6:0]       twin_word;
        bit               quiet;
        bit               found;
        int               r;
        int               gap;

        i_rst_n           = 1'b0;
        in_if.valid       = 1'b0;
        in_if.action      = '0;
        in_if.source_hash = '0;
        in_if.weight      = '0;
        in_if.word_index  = '0;
        out_if.ready      = 1'b0;

        // Find a seed whose draws hit one counter twice within a single add.
        found     = 1'b0;
        twin_hash = '0;
        twin_word = '0;
        for (int s = 1; s < 100000 && !found; s++) begin
            h = 64'(s);
            for (int a = 0; a < 2 * INDEX_PAIRS && !found; a++) begin
                p = draw_pos(h, a);
                for (int b = a + 1; b < 2 * INDEX_PAIRS && !found; b++) begin
                    q = draw_pos(h, b);
                    if (p == q) begin
                        found     = 1'b1;
                        twin_hash = h;
                        twin_word = p[POS_W-1:6];
                    end
                end
            end
        end

        // Directed part: field extremes, every action, the special cases.
        p = draw_pos(64'd0, 0);
        queue_item(ACT_READ,  '0, '0, 7'd0, 0, 1'b0);             // store clean after sweep
        queue_item(ACT_ADD,   64'd0, 5'd1, '0, 0, 1'b0);
        queue_item(ACT_READ,  '0, '0, p[POS_W-1:6], 0, 1'b0);
        queue_item(ACT_ADD,   '1, 5'd16, '1, 0, 1'b0);
        queue_item(ACT_ADD,   64'hAAAA_AAAA_AAAA_AAAA, 5'd31, 7'h55, 2, 1'b0);  // over-range weight
        queue_item(ACT_ADD,   64'h5555_5555_5555_5555, 5'd0, 7'h2A, 0, 1'b0);   // zero weight
        queue_item(ACT_READ,  '1, '1, 7'd127, 0, 1'b0);           // last word of the vector
        queue_item(ACT_READ,  '0, '0, 7'd0, 0, 1'b0);
        queue_item(ACT_UNDEF, '1, '1, '1, 0, 1'b0);               // undecoded action
        queue_item(ACT_UNDEF, '0, '0, '0, 0, 1'b0);
        queue_item(ACT_ADD,   twin_hash, 5'd9, '0, 0, 1'b0);      // repeated position
        queue_item(ACT_ADD,   twin_hash, 5'd9, '0, 0, 1'b0);
        queue_item(ACT_READ,  '0, '0, twin_word, 0, 1'b0);
        queue_item(ACT_CLEAR, '1, '1, '1, 0, 1'b0);
        queue_item(ACT_READ,  '0, '0, twin_word, 0, 1'b0);        // must read back zero
        queue_item(ACT_READ,  '0, '0, p[POS_W-1:6], 3, 1'b0);
        queue_item(ACT_ADD,   64'h8000_0000_0000_0001, 5'd16, '0, 0, 1'b0);
        queue_item(ACT_CLEAR, '0, '0, '0, 0, 1'b0);
        queue_item(ACT_CLEAR, '0, '0, '0, 0, 1'b0);               // back to back clears
        queue_item(ACT_READ,  '0, '0, 7'd64, 0, 1'b0);

        // Random part. A small pool of seeds keeps landing on the same counters so they
        // grow both ways; reads mostly target words an add has just touched.
        foreach (hash_pool[i]) begin
            hash_pool[i] = {$urandom, $urandom};
        end
        last_word = '0;
        quiet     = 1'b0;
        for (int n = 0; n < NUM_RANDOM; n++) begin
            if (n % 250 == 0) begin
                quiet = ($urandom_range(0, 2) == 0);
            end
            r  = $urandom_range(0, 99);
            h  = {$urandom, $urandom};
            w  = 5'($urandom_range(1, 16));
            wd = 7'($urandom_range(0, 127));
            if (r < 58) begin
                act = ACT_ADD;
                if ($urandom_range(0, 4) != 0) begin
                    h = hash_pool[$urandom_range(0, 15)];
                end
                if ($urandom_range(0, 9) == 0) begin
                    w = 5'($urandom_range(0, 31));
                end
                p         = draw_pos(h, int'($urandom_range(0, 2 * INDEX_PAIRS - 1)));
                last_word = p[POS_W-1:6];
            end else if (r < 93) begin
                act = ACT_READ;
                if ($urandom_range(0, 3) != 0) begin
                    wd = last_word;
                end
            end else if (r < 95) begin
                act = ACT_CLEAR;
            end else begin
                act = ACT_UNDEF;
            end
            gap = (quiet || $urandom_range(0, 1) == 0) ? 0 : pause_len();
            queue_item(act, h, w, wd, gap, (n == 700 || n == 1400));
        end

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Run until every beat is in and every result is back, or the block hangs.
        while (!(item_q.size() == 0 && !have_staged && !in_if.valid && result_q.size() == 0)
               && idle_cycles < HANG_LIMIT) begin
            @(posedge i_clk);
        end

        if (idle_cycles >= HANG_LIMIT) begin
            $display("status: fail");
        end else begin
            // catch any stray result beat after the last expected one
            repeat (TAIL_CYCLES) @(posedge i_clk);
            if (fault_count == 0) begin
                $display("status: pass");
            end else begin
                $display("status: fail");
            end
        end
        $finish;
    end

endmodule
